// ===== rtl/wdff_pkg.sv =====
// ----------------------------------------------------------------------------
// wdff_pkg
// Shared types and constants of the duplicate frame filter: controller
// states, response kinds and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package wdff_pkg;

   // Field widths of the 802.11 header, the duplicate counter and the window register.
   localparam int ADDR_W    = 48;
   localparam int OCTET_W   = 8;
   localparam int SEQCTL_W  = 16;
   localparam int SEQ_W     = 12;
   localparam int FRAG_W    = 4;
   localparam int COUNT_W   = 16;
   localparam int CSR_W     = 5;

   // Packed stream widths.
   localparam int REQ_TDATA_W = 128;
   localparam int RSP_TDATA_W = 24;

   // Header bits that decide whether a frame is checked at all.
   localparam int FC0_UNCHECKED_BIT = 2;
   localparam int FC1_MORE_FRAG_BIT = 2;
   localparam int RX_GROUP_BIT      = 40;

   // Window register reset value and the duplicate counter ceiling.
   localparam logic [CSR_W-1:0]   WINDOW_RESET = 5'd10;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ALLOC,
      ST_META,
      ST_LOAD,
      ST_RING,
      ST_UPDATE,
      ST_DONE
   } ctrl_state_type;

   // What the response register is loaded with.
   typedef enum logic [1:0] {
      RSP_PASS,      // forward, untracked, count zero
      RSP_LOOKUP,    // forward, report the existing entry
      RSP_TRACKED    // checked frame, verdict from the ring search
   } rsp_kind_type;

   typedef struct packed {
      logic         latch_req;
      logic         scan_run;
      logic         alloc;
      logic         meta_rd;
      logic         meta_load;
      logic         ring_run;
      logic         update;
      logic         load_rsp;
      rsp_kind_type rsp_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic complete;
      logic unchecked;
      logic scan_done;
      logic src_hit;
      logic free_found;
      logic ring_done;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/wdff_ctrl.sv =====
// ----------------------------------------------------------------------------
// wdff_ctrl
// Sequencer of the duplicate frame filter. Walks one request through the
// source search, allocation or counter read, ring search and update, then hands the result
// to the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module wdff_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_accept,
   input  wdff_pkg::dp_status_type status,
   output wdff_pkg::dp_cmd_type    cmd,
   output logic                   req_ready
);

   wdff_pkg::ctrl_state_type state_ff, state_in;
   wdff_pkg::rsp_kind_type   kind_ff, kind_in;

   // State and response kind registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wdff_pkg::ST_IDLE;
         kind_ff  <= wdff_pkg::RSP_PASS;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      cmd           = '0;
      cmd.rsp_kind  = kind_ff;
      req_ready     = 1'b0;

      unique case (state_ff)
         wdff_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.latch_req = req_accept;
            if (req_accept) begin
               state_in = wdff_pkg::ST_SCAN;
            end
         end
         wdff_pkg::ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (!status.complete) begin
               kind_in  = wdff_pkg::RSP_PASS;
               state_in = wdff_pkg::ST_DONE;
            end else if (status.src_hit) begin
               kind_in  = status.unchecked ? wdff_pkg::RSP_LOOKUP : wdff_pkg::RSP_TRACKED;
               state_in = wdff_pkg::ST_META;
            end else if (status.scan_done) begin
               if (!status.unchecked && status.free_found) begin
                  kind_in  = wdff_pkg::RSP_TRACKED;
                  state_in = wdff_pkg::ST_ALLOC;
               end else begin
                  kind_in  = wdff_pkg::RSP_PASS;
                  state_in = wdff_pkg::ST_DONE;
               end
            end
         end
         wdff_pkg::ST_ALLOC: begin
            cmd.alloc = 1'b1;
            state_in  = wdff_pkg::ST_RING;
         end
         wdff_pkg::ST_META: begin
            cmd.meta_rd = 1'b1;
            state_in    = wdff_pkg::ST_LOAD;
         end
         wdff_pkg::ST_LOAD: begin
            cmd.meta_load = 1'b1;
            state_in = (kind_ff == wdff_pkg::RSP_LOOKUP) ? wdff_pkg::ST_DONE
                                                          : wdff_pkg::ST_RING;
         end
         wdff_pkg::ST_RING: begin
            cmd.ring_run = 1'b1;
            if (status.ring_done) begin
               state_in = wdff_pkg::ST_UPDATE;
            end
         end
         wdff_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = wdff_pkg::ST_DONE;
         end
         wdff_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = wdff_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wdff_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/wdff_dp.sv =====
// ----------------------------------------------------------------------------
// wdff_dp
// Datapath of the duplicate frame filter: request registers, window
// register, source table, per-source counters, sequence rings and the
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module wdff_dp #(
   parameter int MAX_SOURCES = 16,
   parameter int MAX_WINDOW  = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wdff_pkg::dp_cmd_type                cmd,
   output wdff_pkg::dp_status_type             status,
   // Request fields.
   input  wire                                 header_complete,
   input  wire [wdff_pkg::OCTET_W-1:0]         frame_control_0,
   input  wire [wdff_pkg::OCTET_W-1:0]         frame_control_1,
   input  wire [wdff_pkg::ADDR_W-1:0]          receiver_address,
   input  wire [wdff_pkg::ADDR_W-1:0]          transmitter_address,
   input  wire [wdff_pkg::SEQCTL_W-1:0]        sequence_control,
   // Window register write.
   input  wire                                 csr_write,
   input  wire [wdff_pkg::CSR_W-1:0]           csr_wdata,
   // Response register.
   input  wire                                 rsp_ready,
   output logic                                rsp_valid,
   output logic                                forward,
   output logic                                source_tracked,
   output logic [wdff_pkg::COUNT_W-1:0]        duplicate_count
);

   localparam int SRC_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int SCAN_W = $clog2(MAX_SOURCES + 1);
   localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int FILL_W = $clog2(MAX_WINDOW + 1);
   localparam int RING_DEPTH = MAX_SOURCES * MAX_WINDOW;
   localparam int RA_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_WINDOW - 1);

   // ------------------------------------------------------------------------
   // Request registers.
   // ------------------------------------------------------------------------
   logic                          complete_ff;
   logic                          unchecked_ff;
   logic [wdff_pkg::ADDR_W-1:0]   tx_ff;
   logic [wdff_pkg::SEQ_W-1:0]    seq_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         complete_ff  <= header_complete;
         unchecked_ff <= frame_control_0[wdff_pkg::FC0_UNCHECKED_BIT]
                       | receiver_address[wdff_pkg::RX_GROUP_BIT]
                       | frame_control_1[wdff_pkg::FC1_MORE_FRAG_BIT]
                       | (sequence_control[wdff_pkg::FRAG_W-1:0] != '0);
         tx_ff        <= transmitter_address;
         seq_ff       <= sequence_control[wdff_pkg::SEQCTL_W-1:wdff_pkg::FRAG_W];
      end
   end

   // Window register; zero counts as one, large values clip to the ring size.
   logic [wdff_pkg::CSR_W-1:0] win_ff;
   logic [FILL_W-1:0]          win_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= wdff_pkg::WINDOW_RESET;
      end else if (csr_write) begin
         win_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (win_ff == '0) begin
         win_eff = FILL_W'(1);
      end else if (32'(win_ff) > MAX_WINDOW) begin
         win_eff = FILL_W'(MAX_WINDOW);
      end else begin
         win_eff = FILL_W'(win_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Source table search, one entry per cycle with a registered read.
   // ------------------------------------------------------------------------
   logic [MAX_SOURCES-1:0]        valid_ff;
   logic [wdff_pkg::ADDR_W-1:0]   addr_mem [MAX_SOURCES];
   logic [wdff_pkg::ADDR_W-1:0]   addr_q_ff;
   logic [SCAN_W-1:0]             scan_idx_ff;
   logic [SRC_W-1:0]              cmp_idx_ff;
   logic                          cmp_vld_ff;
   logic                          hit_ff;
   logic                          scan_done_ff;
   logic                          free_found_ff;
   logic [SRC_W-1:0]              free_idx_ff;
   logic [SRC_W-1:0]              src_idx_ff;
   logic                          scan_step;
   logic                          scan_issue;
   logic [SRC_W-1:0]              scan_addr;

   assign scan_step  = cmd.scan_run && !hit_ff && !scan_done_ff;
   assign scan_issue = scan_step && (scan_idx_ff < SCAN_W'(MAX_SOURCES));
   assign scan_addr  = scan_idx_ff[SRC_W-1:0];

   // Search control.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         scan_idx_ff   <= '0;
         cmp_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         scan_done_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.latch_req) begin
         scan_idx_ff   <= '0;
         cmp_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         scan_done_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if (scan_step) begin
            cmp_vld_ff <= scan_issue;
            if (scan_issue) begin
               scan_idx_ff <= scan_idx_ff + SCAN_W'(1);
               if (!valid_ff[scan_addr] && !free_found_ff) begin
                  free_found_ff <= 1'b1;
               end
            end
            if (cmp_vld_ff) begin
               if (valid_ff[cmp_idx_ff] && addr_q_ff == tx_ff) begin
                  hit_ff <= 1'b1;
               end
               if (cmp_idx_ff == SRC_W'(MAX_SOURCES - 1)) begin
                  scan_done_ff <= 1'b1;
               end
            end
         end
         if (cmd.alloc) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end
      end
   end

   // Search payload: indexes of the compared, free and chosen entries.
   always_ff @(posedge clock) begin
      if (scan_issue) begin
         cmp_idx_ff <= scan_addr;
         if (!valid_ff[scan_addr] && !free_found_ff) begin
            free_idx_ff <= scan_addr;
         end
      end
      if (scan_step && cmp_vld_ff && valid_ff[cmp_idx_ff] && addr_q_ff == tx_ff) begin
         src_idx_ff <= cmp_idx_ff;
      end else if (cmd.alloc) begin
         src_idx_ff <= free_idx_ff;
      end
   end

   // Source address memory.
   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         addr_mem[free_idx_ff] <= tx_ff;
      end
      if (scan_issue) begin
         addr_q_ff <= addr_mem[scan_addr];
      end
   end

   // ------------------------------------------------------------------------
   // Per-source counters: duplicate count, ring fill and next ring slot.
   // ------------------------------------------------------------------------
   logic [wdff_pkg::COUNT_W-1:0]  cnt_mem  [MAX_SOURCES];
   logic [FILL_W-1:0]             fill_mem [MAX_SOURCES];
   logic [SLOT_W-1:0]             next_mem [MAX_SOURCES];
   logic [wdff_pkg::COUNT_W-1:0]  cnt_q_ff;
   logic [FILL_W-1:0]             fill_q_ff;
   logic [SLOT_W-1:0]             next_q_ff;
   logic [wdff_pkg::COUNT_W-1:0]  cnt_ff,  cnt_in;
   logic [FILL_W-1:0]             fill_ff, fill_in;
   logic [SLOT_W-1:0]             next_ff, next_in;
   logic [FILL_W-1:0]             fill_src;
   logic [SLOT_W-1:0]             next_src;
   logic                          dup_ff;

   assign fill_src = cmd.alloc ? '0 : fill_q_ff;
   assign next_src = cmd.alloc ? '0 : next_q_ff;

   // Counter memories, read by the meta read command, written at update.
   always_ff @(posedge clock) begin
      if (cmd.meta_rd) begin
         cnt_q_ff  <= cnt_mem[src_idx_ff];
         fill_q_ff <= fill_mem[src_idx_ff];
         next_q_ff <= next_mem[src_idx_ff];
      end
      if (cmd.update) begin
         cnt_mem[src_idx_ff]  <= cnt_in;
         fill_mem[src_idx_ff] <= fill_in;
         next_mem[src_idx_ff] <= next_in;
      end
   end

   // Updated counters: count up on a duplicate, else advance the ring.
   always_comb begin
      cnt_in  = cnt_ff;
      fill_in = fill_ff;
      next_in = next_ff;
      if (dup_ff) begin
         if (cnt_ff != wdff_pkg::COUNT_MAX) begin
            cnt_in = cnt_ff + wdff_pkg::COUNT_W'(1);
         end
      end else begin
         next_in = (next_ff == SLOT_LAST) ? '0 : next_ff + SLOT_W'(1);
         if (fill_ff < FILL_W'(MAX_WINDOW)) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   // Working copy of the selected source's counters.
   always_ff @(posedge clock) begin
      if (cmd.alloc || cmd.meta_load) begin
         cnt_ff  <= cmd.alloc ? '0 : cnt_q_ff;
         fill_ff <= fill_src;
         next_ff <= next_src;
      end else if (cmd.update) begin
         cnt_ff  <= cnt_in;
         fill_ff <= fill_in;
         next_ff <= next_in;
      end
   end

   // ------------------------------------------------------------------------
   // Ring search, newest slot first, one slot per cycle.
   // ------------------------------------------------------------------------
   logic [wdff_pkg::SEQ_W-1:0]    ring_mem [RING_DEPTH];
   logic [wdff_pkg::SEQ_W-1:0]    ring_q_ff;
   logic [SLOT_W-1:0]             slot_ff;
   logic [FILL_W-1:0]             ring_n_ff;
   logic [FILL_W-1:0]             issue_cnt_ff;
   logic [FILL_W-1:0]             cmp_cnt_ff;
   logic                          ring_vld_ff;
   logic                          ring_init;
   logic                          ring_step;
   logic                          ring_issue;
   logic [RA_W-1:0]               ring_rd_addr;
   logic [RA_W-1:0]               ring_wr_addr;

   assign ring_init  = cmd.alloc || cmd.meta_load;
   assign ring_step  = cmd.ring_run && !dup_ff;
   assign ring_issue = ring_step && (issue_cnt_ff < ring_n_ff);
   assign ring_rd_addr = RA_W'(32'(src_idx_ff) * MAX_WINDOW + 32'(slot_ff));
   assign ring_wr_addr = RA_W'(32'(src_idx_ff) * MAX_WINDOW + 32'(next_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff  <= 1'b0;
         dup_ff       <= 1'b0;
         issue_cnt_ff <= '0;
         cmp_cnt_ff   <= '0;
         ring_n_ff    <= '0;
         slot_ff      <= '0;
      end else if (ring_init) begin
         ring_vld_ff  <= 1'b0;
         dup_ff       <= 1'b0;
         issue_cnt_ff <= '0;
         cmp_cnt_ff   <= '0;
         ring_n_ff    <= (fill_src < win_eff) ? fill_src : win_eff;
         slot_ff      <= (next_src == '0) ? SLOT_LAST : next_src - SLOT_W'(1);
      end else if (ring_step) begin
         ring_vld_ff <= ring_issue;
         if (ring_issue) begin
            issue_cnt_ff <= issue_cnt_ff + FILL_W'(1);
            slot_ff      <= (slot_ff == '0) ? SLOT_LAST : slot_ff - SLOT_W'(1);
         end
         if (ring_vld_ff) begin
            cmp_cnt_ff <= cmp_cnt_ff + FILL_W'(1);
            if (ring_q_ff == seq_ff) begin
               dup_ff <= 1'b1;
            end
         end
      end
   end

   // Sequence ring memory.
   always_ff @(posedge clock) begin
      if (cmd.update && !dup_ff) begin
         ring_mem[ring_wr_addr] <= seq_ff;
      end
      if (ring_issue) begin
         ring_q_ff <= ring_mem[ring_rd_addr];
      end
   end

   // ------------------------------------------------------------------------
   // Response register.
   // ------------------------------------------------------------------------
   logic                          rsp_valid_ff;
   logic                          fwd_ff;
   logic                          tracked_ff;
   logic [wdff_pkg::COUNT_W-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         unique case (cmd.rsp_kind)
            wdff_pkg::RSP_LOOKUP: begin
               fwd_ff     <= 1'b1;
               tracked_ff <= 1'b1;
               count_ff   <= cnt_ff;
            end
            wdff_pkg::RSP_TRACKED: begin
               fwd_ff     <= !dup_ff;
               tracked_ff <= 1'b1;
               count_ff   <= cnt_ff;
            end
            default: begin
               fwd_ff     <= 1'b1;
               tracked_ff <= 1'b0;
               count_ff   <= '0;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign forward         = fwd_ff;
   assign source_tracked  = tracked_ff;
   assign duplicate_count = count_ff;

   // Status toward the controller.
   always_comb begin
      status.complete   = complete_ff;
      status.unchecked  = unchecked_ff;
      status.scan_done  = scan_done_ff;
      status.src_hit    = hit_ff;
      status.free_found = free_found_ff;
      status.ring_done  = dup_ff || (cmp_cnt_ff == ring_n_ff);
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

`default_nettype wire

// ===== rtl/wifi_duplicate_frame_filter.sv =====
// ----------------------------------------------------------------------------
// wifi_duplicate_frame_filter
// Drops repeated 802.11 frames by keeping the latest sequence numbers of
// each transmitter and counting the duplicates seen per transmitter.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Contents
//  req_    | in        | req_tvalid/tready   | one header per request
//  rsp_    | out       | rsp_tvalid/tready   | verdict, tracking flag, count
//  csr_    | in        | csr_valid/ready     | window size register
//
//  One request at a time; the ring search covers n = min(ring fill, window) slots.
//  The source search reads one table entry per cycle and stops on a match;
//  the ring search reads one sequence slot per cycle and stops on a match.
//  Reset is synchronous and empties the source table at once.
//  A finished result waits in the response register while the next request
//  is accepted; it stalls the sequencer only when a second result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module wifi_duplicate_frame_filter #(
   parameter int MAX_SOURCES = 16,
   parameter int MAX_WINDOW  = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // Request stream.
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // [7:0] frame_control_0, [15:8] frame_control_1, [63:16] receiver_address,
   // [111:64] transmitter_address, [127:112] sequence_control
   input  wire [wdff_pkg::REQ_TDATA_W-1:0]       req_tdata,
   // [0] header_complete
   input  wire                                   req_tuser,
   // Response stream.
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // [0] forward, [1] source_tracked, [17:2] duplicate_count, [23:18] zero
   output logic [wdff_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // Window register write.
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire [wdff_pkg::CSR_W-1:0]             csr_wdata
);

   wdff_pkg::dp_cmd_type    cmd;
   wdff_pkg::dp_status_type status;
   logic                    req_accept;
   logic                    forward;
   logic                    source_tracked;
   logic [wdff_pkg::COUNT_W-1:0] duplicate_count;

   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   wdff_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .status     (status),
      .cmd        (cmd),
      .req_ready  (req_tready)
   );

   wdff_dp #(
      .MAX_SOURCES (MAX_SOURCES),
      .MAX_WINDOW  (MAX_WINDOW)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .header_complete     (req_tuser),
      .frame_control_0     (req_tdata[7:0]),
      .frame_control_1     (req_tdata[15:8]),
      .receiver_address    (req_tdata[63:16]),
      .transmitter_address (req_tdata[111:64]),
      .sequence_control    (req_tdata[127:112]),
      .csr_write           (csr_valid && csr_ready),
      .csr_wdata           (csr_wdata),
      .rsp_ready           (rsp_tready),
      .rsp_valid           (rsp_tvalid),
      .forward             (forward),
      .source_tracked      (source_tracked),
      .duplicate_count     (duplicate_count)
   );

   // Pack the response fields, lowest field first.
   assign rsp_tdata = {6'd0, duplicate_count, source_tracked, forward};

endmodule

`default_nettype wire

// ===== rtl/wdff_checker.sv =====
// ----------------------------------------------------------------------------
// wdff_checker
// Port-level checks of the duplicate frame filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wdff_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_tvalid,
   input wire                                req_tready,
   input wire                                rsp_tvalid,
   input wire                                rsp_tready,
   input wire [wdff_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   // No response is pending right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A request is worked on alone: no second request the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted on two consecutive cycles");

   // A dropped frame always belongs to a tracked source.
   a_drop_tracked: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[1])
      else $error("frame dropped for an untracked source");

   // An untracked source reports a zero count.
   a_untracked_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[17:2] == '0)
      else $error("nonzero count for an untracked source");

   // A stalled response holds its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind wifi_duplicate_frame_filter wdff_checker u_wdff_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== tb/wifi_duplicate_frame_filter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wifi_duplicate_frame_filter_test
// Self-checking bench for the duplicate frame filter. A scoreboard keeps its
// own source table and per-source sequence history, predicts the verdict of
// every accepted header request and compares it with each response, field by
// field. A short directed sequence is followed by random traffic under
// several window settings and idle patterns on both streams.
// ----------------------------------------------------------------------------

module wifi_duplicate_frame_filter_test;

   localparam int MAX_SOURCES = 16;
   localparam int HIST_DEPTH  = 16;
   localparam int POOL_SIZE   = 18;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 64;

   typedef struct {
      bit                          complete;
      bit [wdff_pkg::OCTET_W-1:0]  fc0;
      bit [wdff_pkg::OCTET_W-1:0]  fc1;
      bit [wdff_pkg::ADDR_W-1:0]   rx;
      bit [wdff_pkg::ADDR_W-1:0]   tx;
      bit [wdff_pkg::SEQCTL_W-1:0] seqctl;
   } frame_header_type;

   typedef struct {
      bit                         forward;
      bit                         tracked;
      bit [wdff_pkg::COUNT_W-1:0] count;
   } verdict_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [wdff_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             req_tuser = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [wdff_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [wdff_pkg::CSR_W-1:0]       csr_wdata = '0;

   // Scoreboard copy of the filter state.
   bit [wdff_pkg::CSR_W-1:0]   window_reg = wdff_pkg::WINDOW_RESET;
   bit                         src_used [MAX_SOURCES];
   bit [wdff_pkg::ADDR_W-1:0]  src_addr [MAX_SOURCES];
   bit [wdff_pkg::COUNT_W-1:0] dup_count [MAX_SOURCES];
   bit [wdff_pkg::SEQ_W-1:0]   seq_hist [MAX_SOURCES][HIST_DEPTH];
   int                         hist_fill [MAX_SOURCES];
   bit [3:0]                   hist_head [MAX_SOURCES];

   verdict_type                expected_verdicts [$];
   int                         mismatches = 0;
   int                         idle_cycles = 0;
   int                         send_idle_pct = 0;
   int                         rsp_stall_pct = 0;
   bit [wdff_pkg::ADDR_W-1:0]  addr_pool [POOL_SIZE];

   wifi_duplicate_frame_filter #(
      .MAX_SOURCES(MAX_SOURCES),
      .MAX_WINDOW (HIST_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predict the verdict of one header and update the scoreboard state.
   function automatic verdict_type filter_frame(input frame_header_type h);
      verdict_type v;
      int          entry;
      int          span;
      bit [3:0]    slot;
      bit [wdff_pkg::SEQ_W-1:0] seq;
      bit          hit;
      v.forward = 1'b1;
      v.tracked = 1'b0;
      v.count   = '0;
      if (!h.complete) begin
         return v;
      end
      entry = -1;
      for (int i = MAX_SOURCES - 1; i >= 0; i--) begin
         if (src_used[i] && src_addr[i] == h.tx) entry = i;
      end
      // Unchecked frames only report an existing entry.
      if (h.fc0[wdff_pkg::FC0_UNCHECKED_BIT] || h.rx[wdff_pkg::RX_GROUP_BIT] ||
          h.seqctl[wdff_pkg::FRAG_W-1:0] != '0 ||
          h.fc1[wdff_pkg::FC1_MORE_FRAG_BIT]) begin
         if (entry >= 0) begin
            v.tracked = 1'b1;
            v.count   = dup_count[entry];
         end
         return v;
      end
      // A new source takes the lowest free entry, if there is one.
      if (entry < 0) begin
         for (int i = MAX_SOURCES - 1; i >= 0; i--) begin
            if (!src_used[i]) entry = i;
         end
         if (entry < 0) begin
            return v;
         end
         src_used[entry]  = 1'b1;
         src_addr[entry]  = h.tx;
         dup_count[entry] = '0;
         hist_fill[entry] = 0;
         hist_head[entry] = '0;
      end
      // Compare against the newest min(fill, window) sequence numbers.
      span = (window_reg == 0) ? 1 : (window_reg > HIST_DEPTH) ? HIST_DEPTH : window_reg;
      if (hist_fill[entry] < span) span = hist_fill[entry];
      seq = h.seqctl[wdff_pkg::SEQCTL_W-1:wdff_pkg::FRAG_W];
      hit = 1'b0;
      for (int i = 0; i < span; i++) begin
         slot = hist_head[entry] - 4'd1 - 4'(i);
         if (seq_hist[entry][slot] == seq) hit = 1'b1;
      end
      if (hit) begin
         if (dup_count[entry] != wdff_pkg::COUNT_MAX) dup_count[entry]++;
         v.forward = 1'b0;
      end else begin
         seq_hist[entry][hist_head[entry]] = seq;
         hist_head[entry]++;
         if (hist_fill[entry] < HIST_DEPTH) hist_fill[entry]++;
      end
      v.tracked = 1'b1;
      v.count   = dup_count[entry];
      return v;
   endfunction

   // Watch all three channels: predict on requests, check on responses.
   always @(posedge clock) begin : scoreboard
      frame_header_type hdr;
      verdict_type      want;
      verdict_type      got;
      bit               progress;
      progress = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            window_reg = csr_wdata;
            progress   = 1'b1;
         end
         if (req_tvalid && req_tready) begin
            hdr.complete = req_tuser;
            hdr.fc0      = req_tdata[7:0];
            hdr.fc1      = req_tdata[15:8];
            hdr.rx       = req_tdata[63:16];
            hdr.tx       = req_tdata[111:64];
            hdr.seqctl   = req_tdata[127:112];
            expected_verdicts.push_back(filter_frame(hdr));
            progress = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.forward = rsp_tdata[0];
            got.tracked = rsp_tdata[1];
            got.count   = rsp_tdata[17:2];
            progress    = 1'b1;
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0d/%0d/%0d",
                        $time, got.forward, got.tracked, got.count);
               mismatches++;
            end else begin
               want = expected_verdicts.pop_front();
               if (got.forward != want.forward) begin
                  $display("%0t: forward expected %0d, actual %0d",
                           $time, want.forward, got.forward);
                  mismatches++;
               end
               if (got.tracked != want.tracked) begin
                  $display("%0t: source_tracked expected %0d, actual %0d",
                           $time, want.tracked, got.tracked);
                  mismatches++;
               end
               if (got.count != want.count) begin
                  $display("%0t: duplicate_count expected %0d, actual %0d",
                           $time, want.count, got.count);
                  mismatches++;
               end
            end
         end
      end
      idle_cycles <= progress ? 0 : idle_cycles + 1;
   end

   // Response backpressure.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Stop a hung run.
   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Send one header request, with an optional random gap before it.
   task automatic send_header(input frame_header_type h);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tdata  <= {h.seqctl, h.tx, h.rx, h.fc1, h.fc0};
      req_tuser  <= h.complete;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold off until every predicted response has arrived.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_verdicts.size() != 0);
   endtask

   task automatic write_window(input bit [wdff_pkg::CSR_W-1:0] value);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // A frame that passes every unchecked test, from a given source.
   function automatic frame_header_type checked_frame(
      input bit [wdff_pkg::ADDR_W-1:0] tx,
      input bit [wdff_pkg::SEQ_W-1:0]  seq);
      frame_header_type h;
      h.complete = 1'b1;
      h.fc0      = wdff_pkg::OCTET_W'($urandom);
      h.fc1      = wdff_pkg::OCTET_W'($urandom);
      h.rx       = wdff_pkg::ADDR_W'({$urandom, $urandom});
      h.fc0[wdff_pkg::FC0_UNCHECKED_BIT] = 1'b0;
      h.fc1[wdff_pkg::FC1_MORE_FRAG_BIT] = 1'b0;
      h.rx[wdff_pkg::RX_GROUP_BIT]       = 1'b0;
      h.tx       = tx;
      h.seqctl   = {seq, {wdff_pkg::FRAG_W{1'b0}}};
      return h;
   endfunction

   // Mostly checked frames from known sources with a narrow sequence range,
   // some unchecked frames and some fully random noise.
   function automatic frame_header_type random_frame();
      frame_header_type h;
      int               pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         h.complete = 1'($urandom);
         h.fc0      = wdff_pkg::OCTET_W'($urandom);
         h.fc1      = wdff_pkg::OCTET_W'($urandom);
         h.rx       = wdff_pkg::ADDR_W'({$urandom, $urandom});
         h.tx       = wdff_pkg::ADDR_W'({$urandom, $urandom});
         h.seqctl   = wdff_pkg::SEQCTL_W'($urandom);
         return h;
      end
      h = checked_frame(addr_pool[$urandom_range(0, POOL_SIZE - 1)],
                        ($urandom_range(0, 3) == 0)
                           ? wdff_pkg::SEQ_W'($urandom)
                           : wdff_pkg::SEQ_W'($urandom_range(0, 19)));
      if (pick < 27) begin
         case ($urandom_range(0, 3))
            0: begin
               h.fc0[wdff_pkg::FC0_UNCHECKED_BIT] = 1'b1;
            end
            1: begin
               h.rx[wdff_pkg::RX_GROUP_BIT] = 1'b1;
            end
            2: begin
               h.seqctl[wdff_pkg::FRAG_W-1:0] = wdff_pkg::FRAG_W'($urandom_range(1, 15));
            end
            default: begin
               h.fc1[wdff_pkg::FC1_MORE_FRAG_BIT] = 1'b1;
            end
         endcase
      end
      return h;
   endfunction

   // Incomplete headers are forwarded untracked whatever they hold.
   task automatic test_incomplete_headers();
      frame_header_type h;
      h = '{1'b0, '0, '0, '0, '0, '0};
      send_header(h);
      h = '{1'b0, '1, '1, '1, '1, '1};
      send_header(h);
   endtask

   // First frames from the all-zero and all-ones transmitters.
   task automatic test_new_sources();
      frame_header_type h;
      h = checked_frame(addr_pool[0], '0);
      h.fc0 = '0;
      h.fc1 = '0;
      h.rx  = '0;
      send_header(h);
      h = checked_frame(addr_pool[1], '1);
      h.fc0 = 8'hFB;
      h.fc1 = 8'hFB;
      h.rx  = 48'hFEFF_FFFF_FFFF;
      send_header(h);
   endtask

   // Repeated sequence numbers are dropped and counted.
   task automatic test_duplicate_drop();
      send_header(checked_frame(addr_pool[0], '0));
      send_header(checked_frame(addr_pool[1], '1));
   endtask

   // Each unchecked reason, on known sources and on an unknown one.
   task automatic test_unchecked_frames();
      frame_header_type h;
      h = checked_frame(addr_pool[0], '0);
      h.fc0[wdff_pkg::FC0_UNCHECKED_BIT] = 1'b1;
      send_header(h);
      h = checked_frame(addr_pool[1], '1);
      h.rx[wdff_pkg::RX_GROUP_BIT] = 1'b1;
      send_header(h);
      h = checked_frame(addr_pool[0], '0);
      h.seqctl[wdff_pkg::FRAG_W-1:0] = '1;
      send_header(h);
      h = checked_frame(wdff_pkg::ADDR_W'({$urandom, $urandom}), '0);
      h.fc1[wdff_pkg::FC1_MORE_FRAG_BIT] = 1'b1;
      send_header(h);
   endtask

   // Fill the source table; the last two sources find no free entry.
   task automatic test_table_full();
      for (int i = 2; i < POOL_SIZE; i++) begin
         send_header(checked_frame(addr_pool[i], wdff_pkg::SEQ_W'(i)));
      end
   endtask

   // Random traffic under each window setting, cycling through idle patterns.
   task automatic test_random_traffic();
      bit [wdff_pkg::CSR_W-1:0] windows [8];
      int                       per_phase;
      windows   = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd10, 5'd5, 5'd12,
                    wdff_pkg::CSR_W'($urandom)};
      per_phase = 135;
      for (int p = 0; p < 8; p++) begin
         wait_drained();
         send_idle_pct = (p % 4 == 1) ? 47 : (p % 4 == 3) ? 30 : 0;
         rsp_stall_pct = (p % 4 == 2) ? 47 : (p % 4 == 3) ? 30 : 0;
         write_window(windows[p]);
         for (int k = 0; k < per_phase; k++) begin
            // Let the filter run dry once in every phase.
            if (k == per_phase / 2) wait_drained();
            send_header(random_frame());
         end
      end
   endtask

   initial begin
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) begin
         addr_pool[i] = wdff_pkg::ADDR_W'({$urandom, $urandom});
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_incomplete_headers();
      test_new_sources();
      test_duplicate_drop();
      test_unchecked_frames();
      test_table_full();
      test_random_traffic();

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && expected_verdicts.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== wifi_duplicate_frame_filter.f =====
rtl/wdff_pkg.sv
rtl/wdff_ctrl.sv
rtl/wdff_dp.sv
rtl/wifi_duplicate_frame_filter.sv
rtl/wdff_checker.sv
tb/wifi_duplicate_frame_filter_test.sv
